/* rtl/core/bse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants for the binary search engine.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int POS_W   = 4;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/bse_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_datapath
// Entry table, search bounds, probe compare and result register.
// ----------------------------------------------------------------------------
module bse_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [bse_pkg::CNT_W-1:0]     cfg_wdata,
    input  wire bse_pkg::in_item_t             in_item,
    input  wire bse_pkg::cmd_t                 cmd,
    output bse_pkg::status_t                   status,
    output bse_pkg::out_item_t                 out_item
);

    logic signed [bse_pkg::DATA_W-1:0] table_mem [bse_pkg::DEPTH];

    logic [bse_pkg::CNT_W-1:0]         used_count_reg;
    logic [bse_pkg::CNT_W-1:0]         lo_reg, lo_next;
    logic [bse_pkg::CNT_W-1:0]         end_reg, end_next;
    logic signed [bse_pkg::DATA_W-1:0] key_reg;
    bse_pkg::out_item_t                result_reg;

    logic [bse_pkg::CNT_W-1:0]         count_sat;
    logic [bse_pkg::CNT_W:0]           mid_sum;
    logic [bse_pkg::ADDR_W-1:0]        mid;
    logic signed [bse_pkg::DATA_W-1:0] probe;
    logic                              active;
    logic                              match;
    logic                              less;

    // table writes
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            table_mem[in_item.slot[bse_pkg::ADDR_W-1:0]] <= in_item.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_count_reg <= '0;
        end else if (cfg_we) begin
            used_count_reg <= cfg_wdata;
        end
    end

    assign count_sat = (used_count_reg > bse_pkg::CNT_W'(bse_pkg::DEPTH))
                     ? bse_pkg::CNT_W'(bse_pkg::DEPTH) : used_count_reg;

    // floor midpoint of the inclusive bounds lo .. end-1
    assign mid_sum = {1'b0, lo_reg} + {1'b0, end_reg} - (bse_pkg::CNT_W+1)'(1);
    assign mid     = mid_sum[bse_pkg::ADDR_W:1];
    assign probe   = table_mem[mid];
    assign active  = lo_reg < end_reg;
    assign match   = active && (probe == key_reg);
    assign less    = probe < key_reg;

    assign status.done = !active || match;

    always_comb begin
        lo_next  = lo_reg;
        end_next = end_reg;
        if (cmd.start) begin
            lo_next  = '0;
            end_next = count_sat;
        end else if (cmd.step) begin
            if (less) begin
                lo_next = bse_pkg::CNT_W'(mid) + bse_pkg::CNT_W'(1);
            end else begin
                end_next = bse_pkg::CNT_W'(mid);
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        end_reg <= end_next;
        if (cmd.start) begin
            key_reg <= in_item.value;
        end
        if (cmd.finish) begin
            result_reg.found    <= match;
            result_reg.position <= match ? bse_pkg::POS_W'(mid) : '0;
        end
    end

    assign out_item = result_reg;

endmodule

`default_nettype wire

/* rtl/core/bse_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_ctrl
// Request handshake and search sequencing.
// ----------------------------------------------------------------------------
module bse_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_mode,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire bse_pkg::status_t  status,
    output bse_pkg::cmd_t          cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic accept;
    logic out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_mode == bse_pkg::MODE_SEARCH) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SEARCH;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                if (status.done) begin
                    if (out_free) begin
                        cmd.finish   = 1'b1;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/binary_search_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_search_engine
// Sixteen-entry signed table with load and binary search requests.
// ----------------------------------------------------------------------------
// A load request writes one table entry and gives no result. A search request
// probes one table entry per cycle through a single read port of the table,
// up to five probes over sixteen entries, and holds s_ready low until the
// result is registered: on a match, or once the last probe narrows the bounds
// to empty. A search finishes only once the previous result has been taken.
// used_count may only be written while the engine is idle.
module binary_search_engine (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [bse_pkg::CNT_W-1:0]  cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire bse_pkg::in_item_t          s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output bse_pkg::out_item_t              m_data
);

    bse_pkg::cmd_t    cmd;
    bse_pkg::status_t status;

    bse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_data.mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bse_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_item   (s_data),
        .cmd       (cmd),
        .status    (status),
        .out_item  (m_data)
    );

endmodule

`default_nettype wire

/* rtl/core/bse_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_checker
// Port-level checks for the binary search engine.
// ----------------------------------------------------------------------------
module bse_checker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire bse_pkg::in_item_t   s_data,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire bse_pkg::out_item_t  m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_miss_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.position == '0)
        else $error("miss with nonzero position");

    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.mode == bse_pkg::MODE_LOAD && !m_valid
        |=> !m_valid)
        else $error("load request produced a result");

    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.mode == bse_pkg::MODE_SEARCH |=> !s_ready)
        else $error("request taken during search");

endmodule

bind binary_search_engine bse_checker u_bse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
